/* sv/sgdau_pkg.sv */
package sgdau_pkg;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 12;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam int LR_W     = 17;
    localparam int BS_W     = 16;
    localparam int LAMBDA_W = 17;
    localparam int CLIP_W   = 31;

    localparam logic [LR_W-1:0]     LR_RESET     = 17'd655;
    localparam logic [BS_W-1:0]     BS_RESET     = 16'd32;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 17'd0;
    localparam logic [CLIP_W-1:0]   CLIP_RESET   = 31'd327680;

    localparam int                  DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [OP_W-1:0] {
        OP_ACC_WEIGHT = 3'd0,
        OP_ACC_BIAS   = 3'd1,
        OP_UPDATE     = 3'd2,
        OP_LOAD       = 3'd3,
        OP_READ       = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_BATCH_SIZE = 2'd1,
        CFG_L2_LAMBDA  = 2'd2,
        CFG_GRAD_CLIP  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_PROD = 2'd1,
        MUL_L2   = 2'd2,
        MUL_STEP = 2'd3
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_CLEAR    = 4'd0,
        ST_IDLE     = 4'd1,
        ST_ADDR     = 4'd2,
        ST_READ     = 4'd3,
        ST_DIV_INIT = 4'd4,
        ST_DIV      = 4'd5,
        ST_GSUM     = 4'd6,
        ST_STEP     = 4'd7,
        ST_FIN      = 4'd8
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] delta;
        logic signed [DATA_W-1:0] activation;
        logic                     is_bias;
        logic signed [DATA_W-1:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic     cap;
        logic     addr_en;
        logic     rd_en;
        logic     clr;
        logic     div_start;
        logic     div_step;
        logic     gsum;
        logic     finish;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic out_ready;
        logic is_update;
    } t_dp_sts;

endpackage

/* sv/sgdau_ctrl.sv */
module sgdau_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sgdau_pkg::t_dp_sts i_sts,
    output logic               o_in_stall,
    output sgdau_pkg::t_dp_cmd o_cmd
);

    sgdau_pkg::t_state r_state;
    sgdau_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgdau_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgdau_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = sgdau_pkg::ST_IDLE;
            end
            sgdau_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sgdau_pkg::ST_ADDR;
            end
            sgdau_pkg::ST_ADDR: begin
                n_state = sgdau_pkg::ST_READ;
            end
            sgdau_pkg::ST_READ: begin
                n_state = i_sts.is_update ? sgdau_pkg::ST_DIV_INIT : sgdau_pkg::ST_FIN;
            end
            sgdau_pkg::ST_DIV_INIT: begin
                n_state = sgdau_pkg::ST_DIV;
            end
            sgdau_pkg::ST_DIV: begin
                if (i_sts.div_last) n_state = sgdau_pkg::ST_GSUM;
            end
            sgdau_pkg::ST_GSUM: begin
                n_state = sgdau_pkg::ST_STEP;
            end
            sgdau_pkg::ST_STEP: begin
                n_state = sgdau_pkg::ST_FIN;
            end
            sgdau_pkg::ST_FIN: begin
                if (i_sts.out_ready) n_state = sgdau_pkg::ST_IDLE;
            end
            default: begin
                n_state = sgdau_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = sgdau_pkg::MUL_NONE;
        o_in_stall    = 1'b1;
        unique case (r_state)
            sgdau_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            sgdau_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.cap  = i_in_valid;
            end
            sgdau_pkg::ST_ADDR: begin
                o_cmd.addr_en = 1'b1;
            end
            sgdau_pkg::ST_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.mul_sel = sgdau_pkg::MUL_PROD;
            end
            sgdau_pkg::ST_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                o_cmd.mul_sel   = sgdau_pkg::MUL_L2;
            end
            sgdau_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            sgdau_pkg::ST_GSUM: begin
                o_cmd.gsum = 1'b1;
            end
            sgdau_pkg::ST_STEP: begin
                o_cmd.mul_sel = sgdau_pkg::MUL_STEP;
            end
            sgdau_pkg::ST_FIN: begin
                o_cmd.finish = i_sts.out_ready;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* sv/sgdau_datapath.sv */
module sgdau_datapath #(
    parameter int ENTRIES   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sgdau_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgdau_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  sgdau_pkg::t_in_item                 i_in_item,
    input  sgdau_pkg::t_dp_cmd                  i_cmd,
    output sgdau_pkg::t_dp_sts                  o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sgdau_pkg::t_out_item                o_out_item
);

    localparam int DW    = sgdau_pkg::DATA_W;
    localparam int AW    = $clog2(ENTRIES);
    localparam int QP_W  = sgdau_pkg::IDX_W + 33;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / ENTRIES);
    localparam int L2_W  = sgdau_pkg::LAMBDA_W + DW - 1 - FRAC_BITS;
    localparam int GW    = ((L2_W > DW) ? L2_W : DW) + 2;
    localparam int MA_W  = DW + 1;
    localparam int PW    = MA_W + GW;
    localparam int RW    = PW + 1;
    localparam logic signed [RW-1:0] HALF    = RW'(1) << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX = RW'(33'sh0_7fff_ffff);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(32'sh8000_0000);

    logic [sgdau_pkg::LR_W-1:0]     r_lr;
    logic [sgdau_pkg::BS_W-1:0]     r_bs;
    logic [sgdau_pkg::LAMBDA_W-1:0] r_lambda;
    logic [sgdau_pkg::CLIP_W-1:0]   r_clip;

    logic signed [DW-1:0] r_wmem [ENTRIES];
    logic signed [DW-1:0] r_gmem [ENTRIES];

    sgdau_pkg::t_in_item           r_item;
    logic [sgdau_pkg::IDX_W-1:0]   r_quot;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_clr_addr;
    logic signed [DW-1:0]          r_wrd;
    logic signed [DW-1:0]          r_grd;
    logic signed [PW-1:0]          r_prod;
    logic signed [GW-1:0]          r_g;
    logic [DW-1:0]                 r_div_q;
    logic [sgdau_pkg::BS_W-1:0]    r_div_rem;
    logic [sgdau_pkg::BS_W-1:0]    r_div_d;
    logic                          r_div_neg;
    logic [sgdau_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                          r_out_valid;
    sgdau_pkg::t_out_item          r_out_item;

    logic [31:0]                   q_times_e;
    logic [31:0]                   rem_raw;
    logic [31:0]                   rem_fix;
    logic signed [MA_W-1:0]        mul_a;
    logic signed [GW-1:0]          mul_b;
    logic signed [RW-1:0]          rnd_sum;
    logic signed [RW-1:0]          rnd;
    logic signed [RW-1:0]          lim;
    logic signed [RW-1:0]          p_clip;
    logic signed [RW-1:0]          fin_val;
    logic                          sat_ovf;
    logic signed [DW-1:0]          sat_val;
    logic signed [GW-1:0]          avg;
    logic signed [GW-1:0]          l2_term;
    logic [sgdau_pkg::BS_W:0]      div_sh;
    logic [DW-1:0]                 grd_mag;
    logic signed [DW-1:0]          res_val;
    logic                          res_sat;
    logic                          g_we;
    logic [AW-1:0]                 g_wa;
    logic signed [DW-1:0]          g_wd;
    logic                          w_we;
    logic signed [DW-1:0]          w_wd;
    logic                          out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= sgdau_pkg::LR_RESET;
            r_bs     <= sgdau_pkg::BS_RESET;
            r_lambda <= sgdau_pkg::LAMBDA_RESET;
            r_clip   <= sgdau_pkg::CLIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgdau_pkg::CFG_LEARN_RATE: r_lr     <= i_cfg_data[sgdau_pkg::LR_W-1:0];
                sgdau_pkg::CFG_BATCH_SIZE: r_bs     <= i_cfg_data[sgdau_pkg::BS_W-1:0];
                sgdau_pkg::CFG_L2_LAMBDA:  r_lambda <= i_cfg_data[sgdau_pkg::LAMBDA_W-1:0];
                sgdau_pkg::CFG_GRAD_CLIP:  r_clip   <= i_cfg_data[sgdau_pkg::CLIP_W-1:0];
                default: r_lr <= r_lr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.div_start) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + sgdau_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        q_times_e = 32'(r_quot) * 32'(ENTRIES);
        rem_raw   = 32'(r_item.index) - q_times_e;
        rem_fix   = (rem_raw >= 32'(ENTRIES)) ? rem_raw - 32'(ENTRIES) : rem_raw;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            sgdau_pkg::MUL_PROD: begin
                mul_a = MA_W'(r_item.delta);
                mul_b = GW'(r_item.activation);
            end
            sgdau_pkg::MUL_L2: begin
                mul_a = $signed(MA_W'(r_lambda));
                mul_b = GW'(r_wrd);
            end
            sgdau_pkg::MUL_STEP: begin
                mul_a = $signed(MA_W'(r_lr));
                mul_b = r_g;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        rnd_sum = RW'(r_prod) + HALF;
        rnd     = rnd_sum >>> FRAC_BITS;
        lim     = $signed(RW'(r_clip));
        if (rnd > lim) begin
            p_clip = lim;
        end else if (rnd < -lim) begin
            p_clip = -lim;
        end else begin
            p_clip = rnd;
        end
        avg     = r_div_neg ? -$signed(GW'(r_div_q)) : $signed(GW'(r_div_q));
        l2_term = r_item.is_bias ? '0 : GW'(rnd);
        div_sh  = {r_div_rem, r_div_q[DW-1]};
        grd_mag = r_grd[DW-1] ? DW'(-r_grd) : DW'(r_grd);
    end

    always_comb begin
        case (r_item.op)
            sgdau_pkg::OP_ACC_WEIGHT: fin_val = RW'(r_grd) + p_clip;
            sgdau_pkg::OP_ACC_BIAS:   fin_val = RW'(r_grd) + RW'(r_item.delta);
            sgdau_pkg::OP_UPDATE:     fin_val = RW'(r_wrd) - rnd;
            default:                  fin_val = '0;
        endcase
        sat_ovf = (fin_val > SAT_MAX) || (fin_val < SAT_MIN);
        if (fin_val > SAT_MAX) begin
            sat_val = DW'(SAT_MAX);
        end else if (fin_val < SAT_MIN) begin
            sat_val = DW'(SAT_MIN);
        end else begin
            sat_val = DW'(fin_val);
        end
    end

    always_comb begin
        res_val = '0;
        res_sat = 1'b0;
        case (r_item.op) inside
            sgdau_pkg::OP_ACC_WEIGHT, sgdau_pkg::OP_ACC_BIAS, sgdau_pkg::OP_UPDATE: begin
                res_val = sat_val;
                res_sat = sat_ovf;
            end
            sgdau_pkg::OP_LOAD: res_val = r_item.load_value;
            sgdau_pkg::OP_READ: res_val = r_wrd;
            default:            res_val = '0;
        endcase
    end

    always_comb begin
        g_we = i_cmd.clr || (i_cmd.finish && ((r_item.op == sgdau_pkg::OP_ACC_WEIGHT)
               || (r_item.op == sgdau_pkg::OP_ACC_BIAS) || (r_item.op == sgdau_pkg::OP_UPDATE)));
        g_wa = i_cmd.clr ? r_clr_addr : r_addr;
        g_wd = (i_cmd.clr || (r_item.op == sgdau_pkg::OP_UPDATE)) ? '0 : sat_val;
        w_we = i_cmd.finish && ((r_item.op == sgdau_pkg::OP_UPDATE)
               || (r_item.op == sgdau_pkg::OP_LOAD));
        w_wd = (r_item.op == sgdau_pkg::OP_LOAD) ? r_item.load_value : sat_val;
    end

    always_ff @(posedge i_clk) begin
        if (g_we) r_gmem[g_wa] <= g_wd;
        if (i_cmd.rd_en) r_grd <= r_gmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[r_addr] <= w_wd;
        if (i_cmd.rd_en) r_wrd <= r_wmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_in_item;
            r_quot <= sgdau_pkg::IDX_W'((QP_W'(i_in_item.index) * QP_W'(RECIP)) >> 32);
        end
        if (i_cmd.addr_en) r_addr <= AW'(rem_fix);
        if (i_cmd.mul_sel != sgdau_pkg::MUL_NONE) r_prod <= PW'(mul_a) * PW'(mul_b);
        if (i_cmd.div_start) begin
            r_div_q   <= grd_mag;
            r_div_rem <= '0;
            r_div_d   <= (r_bs == '0) ? sgdau_pkg::BS_W'(1) : r_bs;
            r_div_neg <= r_grd[DW-1];
        end else if (i_cmd.div_step) begin
            if (div_sh >= {1'b0, r_div_d}) begin
                r_div_rem <= sgdau_pkg::BS_W'(div_sh - {1'b0, r_div_d});
                r_div_q   <= {r_div_q[DW-2:0], 1'b1};
            end else begin
                r_div_rem <= sgdau_pkg::BS_W'(div_sh);
                r_div_q   <= {r_div_q[DW-2:0], 1'b0};
            end
        end
        if (i_cmd.gsum) r_g <= avg + l2_term;
        if (i_cmd.finish) begin
            r_out_item.result_value <= res_val;
            r_out_item.saturated    <= res_sat;
        end
    end

    assign out_ready       = !r_out_valid || !i_out_stall;
    assign o_sts.clr_last  = (r_clr_addr == AW'(ENTRIES - 1));
    assign o_sts.div_last  = (r_div_cnt == sgdau_pkg::DIV_LAST);
    assign o_sts.out_ready = out_ready;
    assign o_sts.is_update = (r_item.op == sgdau_pkg::OP_UPDATE);
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

/* sv/sgd_gradient_accumulate_update.sv */
// Accumulate, load, read and unknown ops pass the address, read and finish states; an update
// also passes divider init, the 32-step restoring divider for the batch average, gradient
// sum and step. No new item is taken until the last result is in the output register.
// A result waits in the output register while the next item is already being worked on.
// Reset is synchronous and active low; afterwards the gradient store is cleared one entry
// per cycle, every entry in turn, before the first item is accepted.
module sgd_gradient_accumulate_update #(
    parameter int ENTRIES   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sgdau_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgdau_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sgdau_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sgdau_pkg::t_out_item             o_out_item
);

    sgdau_pkg::t_dp_cmd cmd;
    sgdau_pkg::t_dp_sts sts;

    sgdau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sgdau_datapath #(
        .ENTRIES   (ENTRIES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* sv/sgdau_checker.sv */
module sgdau_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input sgdau_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled output item changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input accepted again right after an accepted item.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("Result appeared too soon after acceptance.");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Result appeared while the block was idle.");

endmodule

bind sgd_gradient_accumulate_update sgdau_checker u_sgdau_checker (.*);
